/* hw/rtl/disk_request_sequencer_retry_top_assert.svh */
// Assertion macros used by the RTL top file of the disk request sequencer.
`ifndef DISK_REQUEST_SEQUENCER_RETRY_TOP_ASSERT_SVH
`define DISK_REQUEST_SEQUENCER_RETRY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define DRSR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The condition must never be true outside reset.
`define DRSR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define DRSR_ASSERT(label, clk, rst_n, prop)
`define DRSR_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/drsr_pkg.sv */
package drsr_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CFG_ADDR_W = 3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_MAX_RETRIES = 1'b0;
	localparam logic REG_BLOCK_LIMIT = 1'b1;

	localparam logic [3:0] MAX_RETRIES_RESET = 4'd10;
	localparam logic [12:0] BLOCK_LIMIT_RESET = 13'd616;

	localparam logic REQ_SUBMIT = 1'b0;
	localparam logic REQ_EVENT = 1'b1;

	localparam logic [2:0] OUT_ISSUE = 3'd0;
	localparam logic [2:0] OUT_DONE_OK = 3'd1;
	localparam logic [2:0] OUT_DONE_ERR = 3'd2;
	localparam logic [2:0] OUT_REJ_RANGE = 3'd3;
	localparam logic [2:0] OUT_REJ_FULL = 3'd4;

	localparam logic [15:0] STATUS_ERR_MASK = 16'h7000;
	localparam logic [15:0] CMD_IENABLE = 16'h2000;
	localparam logic [15:0] CMD_WRITE = 16'h8000;
	localparam logic [15:0] BLOCK_BYTES = 16'd512;

	typedef struct packed {
		logic req_type;
		logic unit;
		logic [15:0] start_block;
		logic [15:0] buffer_addr;
		logic [7:0] block_count;
		logic is_read;
		logic [15:0] status_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic out_unit;
		logic [15:0] out_addr;
		logic [15:0] command_word;
		logic last;
	} out_item_t;

	// One queued request, 43 bits.
	typedef struct packed {
		logic unit;
		logic [15:0] block;
		logic [15:0] addr;
		logic [7:0] count;
		logic rd;
		logic err;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CMPL,
		ST_NEXT
	} state_t;

endpackage

/* hw/rtl/drsr_ram.sv */
module drsr_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/disk_request_sequencer_retry_top.sv */
// Disk request sequencer: requests for two disk units wait in a FIFO held in a
// single request RAM (one write and one read port, registered read), and one
// single-block command is issued at a time for the request at the head. An
// item is taken into an input register and then executed: a submit is
// accepted, then range/full checked and written to the RAM; a completion event
// is accepted, then the head entry is read from the RAM, modified and written
// back, or it is dropped when it arrives while no command is outstanding. A
// finished request followed by the first block of the next one also passes
// through ST_NEXT, since that needs a second read of the RAM. Each step after
// the accept waits while the output register still holds an untaken result item. The RAM needs no
// clearing after reset: an entry is read only after it has been written.
`include "disk_request_sequencer_retry_top_assert.svh"

module disk_request_sequencer_retry_top #(
	parameter int QUEUE_DEPTH = drsr_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input drsr_pkg::in_item_t cmd_item,
	output logic rsp_valid,
	input logic rsp_ready,
	output drsr_pkg::out_item_t rsp_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [drsr_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	function automatic drsr_pkg::out_item_t issue_item(drsr_pkg::entry_t e);
		drsr_pkg::out_item_t r;
		r.outcome = drsr_pkg::OUT_ISSUE;
		r.out_unit = e.unit;
		r.out_addr = e.addr;
		r.command_word = e.block | drsr_pkg::CMD_IENABLE |
			(e.rd ? 16'd0 : drsr_pkg::CMD_WRITE);
		r.last = 1'b1;
		return r;
	endfunction

	function automatic drsr_pkg::out_item_t status_item(logic [2:0] oc, logic u, logic lst);
		drsr_pkg::out_item_t r;
		r.outcome = oc;
		r.out_unit = u;
		r.out_addr = 16'd0;
		r.command_word = 16'd0;
		r.last = lst;
		return r;
	endfunction

	drsr_pkg::state_t state_q, state_d;
	drsr_pkg::in_item_t item_q;
	drsr_pkg::out_item_t rsp_q, rsp_d;
	logic rsp_valid_q, rsp_load, rsp_free;

	logic [3:0] max_retries_q;
	logic [12:0] block_limit_q;
	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
	logic [CNT_W-1:0] count_q, count_d, count_dec;
	logic busy_q, busy_d;
	logic [4:0] retry_q, retry_d, retry_inc;

	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	drsr_pkg::entry_t ram_wdata, ram_rdata, new_e, upd_e;

	logic cfg_wr;
	logic ev_err, do_retry, err_flag, blk_done, more;
	logic [7:0] cnt_dec;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q <= drsr_pkg::MAX_RETRIES_RESET;
			block_limit_q <= drsr_pkg::BLOCK_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				drsr_pkg::REG_MAX_RETRIES: max_retries_q <= pwdata[3:0];
				drsr_pkg::REG_BLOCK_LIMIT: block_limit_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			drsr_pkg::REG_MAX_RETRIES: prdata = {28'd0, max_retries_q};
			drsr_pkg::REG_BLOCK_LIMIT: prdata = {19'd0, block_limit_q};
			default: prdata = 32'd0;
		endcase
	end

	// Request RAM
	drsr_ram #(
		.WIDTH($bits(drsr_pkg::entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Datapath terms
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign more = (count_dec != '0);

	assign new_e.unit = item_q.unit;
	assign new_e.block = item_q.start_block;
	assign new_e.addr = item_q.buffer_addr;
	assign new_e.count = item_q.block_count;
	assign new_e.rd = item_q.is_read;
	assign new_e.err = 1'b0;

	assign ev_err = (item_q.status_word & drsr_pkg::STATUS_ERR_MASK) != 16'd0;
	assign retry_inc = retry_q + 5'd1;
	assign do_retry = ev_err && (retry_inc <= {1'b0, max_retries_q});
	// Reaching the fall-through path with an error means retries ran out.
	assign err_flag = ram_rdata.err | ev_err;
	assign cnt_dec = ram_rdata.count - 8'd1;
	assign blk_done = (cnt_dec == 8'd0);

	assign upd_e.unit = ram_rdata.unit;
	assign upd_e.block = ram_rdata.block + 16'd1;
	assign upd_e.addr = ram_rdata.addr + drsr_pkg::BLOCK_BYTES;
	assign upd_e.count = cnt_dec;
	assign upd_e.rd = ram_rdata.rd;
	assign upd_e.err = err_flag;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			drsr_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = drsr_pkg::ST_EXEC;
				end
			end
			drsr_pkg::ST_EXEC: begin
				if (rsp_free) begin
					if (item_q.req_type == drsr_pkg::REQ_EVENT && busy_q) begin
						state_d = drsr_pkg::ST_CMPL;
					end else begin
						state_d = drsr_pkg::ST_IDLE;
					end
				end
			end
			drsr_pkg::ST_CMPL: begin
				if (rsp_free) begin
					if (!do_retry && blk_done && more) begin
						state_d = drsr_pkg::ST_NEXT;
					end else begin
						state_d = drsr_pkg::ST_IDLE;
					end
				end
			end
			drsr_pkg::ST_NEXT: begin
				if (rsp_free) begin
					state_d = drsr_pkg::ST_IDLE;
				end
			end
			default: state_d = drsr_pkg::ST_IDLE;
		endcase
	end

	// Outputs and queue updates
	always_comb begin
		cmd_ready = (state_q == drsr_pkg::ST_IDLE);
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = new_e;
		ram_raddr = head_q;
		rsp_load = 1'b0;
		rsp_d = status_item(drsr_pkg::OUT_ISSUE, 1'b0, 1'b1);
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		busy_d = busy_q;
		retry_d = retry_q;
		case (state_q)
			drsr_pkg::ST_EXEC: begin
				if (rsp_free) begin
					if (item_q.req_type == drsr_pkg::REQ_SUBMIT) begin
						if (item_q.start_block >= {3'd0, block_limit_q}) begin
							rsp_load = 1'b1;
							rsp_d = status_item(drsr_pkg::OUT_REJ_RANGE, item_q.unit, 1'b1);
						end else if (count_q == FULL_CNT) begin
							rsp_load = 1'b1;
							rsp_d = status_item(drsr_pkg::OUT_REJ_FULL, item_q.unit, 1'b1);
						end else begin
							ram_we = 1'b1;
							tail_d = tail_inc;
							count_d = count_q + 1'b1;
							// An idle sequencer has an empty queue, so the new
							// request is the head and is issued from the item.
							if (!busy_q) begin
								rsp_load = 1'b1;
								rsp_d = issue_item(new_e);
								busy_d = 1'b1;
							end
						end
					end else if (busy_q) begin
						ram_re = 1'b1;
					end
				end
			end
			drsr_pkg::ST_CMPL: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					if (do_retry) begin
						retry_d = retry_inc;
						rsp_d = issue_item(ram_rdata);
					end else begin
						retry_d = 5'd0;
						if (blk_done) begin
							rsp_d = status_item(err_flag ? drsr_pkg::OUT_DONE_ERR :
								drsr_pkg::OUT_DONE_OK, ram_rdata.unit, !more);
							head_d = head_inc;
							count_d = count_dec;
							if (more) begin
								ram_re = 1'b1;
								ram_raddr = head_inc;
							end else begin
								busy_d = 1'b0;
							end
						end else begin
							ram_we = 1'b1;
							ram_waddr = head_q;
							ram_wdata = upd_e;
							rsp_d = issue_item(upd_e);
						end
					end
				end
			end
			drsr_pkg::ST_NEXT: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					rsp_d = issue_item(ram_rdata);
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drsr_pkg::ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
			retry_q <= 5'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
			busy_q <= busy_d;
			retry_q <= retry_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_q <= cmd_item;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_q;

	`DRSR_ASSERT(a_busy_tracks_queue, clk, arst_n, busy_q == (count_q != '0))
	`DRSR_ASSERT(a_count_bounded, clk, arst_n, count_q <= FULL_CNT)
	`DRSR_ASSERT_NEVER(a_retry_bounded, clk, arst_n, retry_q[4])
	`DRSR_ASSERT(a_next_has_request, clk, arst_n, (state_q == drsr_pkg::ST_NEXT) |-> (count_q != '0 && busy_q))

endmodule

/* tb/disk_request_sequencer_retry_top_tb.sv */
`timescale 1ns / 100ps

module disk_request_sequencer_retry_top_tb;

	localparam int QD = drsr_pkg::QUEUE_DEPTH;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	drsr_pkg::in_item_t cmd_item = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	drsr_pkg::out_item_t rsp_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [drsr_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// No idling on either side while this is set.
	logic steady = 1'b0;

	drsr_pkg::in_item_t pending_items[$];
	drsr_pkg::out_item_t expected_rsp[$];

	// Shadow of the sequencer state.
	logic [3:0] cfg_max_retries = drsr_pkg::MAX_RETRIES_RESET;
	logic [12:0] cfg_block_limit = drsr_pkg::BLOCK_LIMIT_RESET;
	drsr_pkg::entry_t req_store[QD];
	logic [$clog2(QD)-1:0] q_head = '0;
	logic [$clog2(QD)-1:0] q_tail = '0;
	int q_count = 0;
	logic q_busy = 1'b0;
	logic [4:0] retry_cnt = '0;

	int mismatches = 0;
	int n_submits = 0;
	int n_events = 0;
	int n_results = 0;
	int n_issue = 0;
	int n_done_ok = 0;
	int n_done_err = 0;
	int n_rej_range = 0;
	int n_rej_full = 0;

	disk_request_sequencer_retry_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_item(cmd_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("disk_request_sequencer_retry_top verification failed");
		$finish;
	end

	function automatic drsr_pkg::out_item_t status_item(input logic [2:0] oc, input logic u);
		drsr_pkg::out_item_t r;
		r = '0;
		r.outcome = oc;
		r.out_unit = u;
		return r;
	endfunction

	// Command for the current block of the request at the head of the queue.
	function automatic drsr_pkg::out_item_t issue_head();
		drsr_pkg::entry_t e;
		drsr_pkg::out_item_t r;
		e = req_store[q_head];
		q_busy = 1'b1;
		r = '0;
		r.outcome = drsr_pkg::OUT_ISSUE;
		r.out_unit = e.unit;
		r.out_addr = e.addr;
		r.command_word = e.block | drsr_pkg::CMD_IENABLE |
			(e.rd ? 16'h0000 : drsr_pkg::CMD_WRITE);
		return r;
	endfunction

	function automatic void predict_step(input drsr_pkg::in_item_t it);
		drsr_pkg::out_item_t res[$];
		drsr_pkg::entry_t e;
		logic retried;
		retried = 1'b0;
		if (it.req_type == drsr_pkg::REQ_SUBMIT) begin
			if (it.start_block >= {3'b000, cfg_block_limit}) begin
				res.push_back(status_item(drsr_pkg::OUT_REJ_RANGE, it.unit));
			end else if (q_count >= QD) begin
				res.push_back(status_item(drsr_pkg::OUT_REJ_FULL, it.unit));
			end else begin
				e.unit = it.unit;
				e.block = it.start_block;
				e.addr = it.buffer_addr;
				e.count = it.block_count;
				e.rd = it.is_read;
				e.err = 1'b0;
				req_store[q_tail] = e;
				q_tail = q_tail + 1'b1;
				q_count++;
				if (!q_busy)
					res.push_back(issue_head());
			end
		end else if (q_busy && q_count != 0) begin
			q_busy = 1'b0;
			if ((it.status_word & drsr_pkg::STATUS_ERR_MASK) != 16'h0000) begin
				retry_cnt = retry_cnt + 1'b1;
				if (retry_cnt <= {1'b0, cfg_max_retries}) begin
					res.push_back(issue_head());
					retried = 1'b1;
				end else begin
					req_store[q_head].err = 1'b1;
				end
			end
			if (!retried) begin
				retry_cnt = '0;
				req_store[q_head].count = req_store[q_head].count - 1'b1;
				if (req_store[q_head].count == 8'd0) begin
					res.push_back(status_item(req_store[q_head].err ?
						drsr_pkg::OUT_DONE_ERR : drsr_pkg::OUT_DONE_OK,
						req_store[q_head].unit));
					q_head = q_head + 1'b1;
					q_count--;
					if (q_count != 0)
						res.push_back(issue_head());
				end else begin
					req_store[q_head].addr = req_store[q_head].addr + drsr_pkg::BLOCK_BYTES;
					req_store[q_head].block = req_store[q_head].block + 1'b1;
					res.push_back(issue_head());
				end
			end
		end else begin
			q_busy = 1'b0;
		end
		foreach (res[i]) begin
			res[i].last = (i == res.size() - 1);
			expected_rsp.push_back(res[i]);
		end
	endfunction

	function automatic drsr_pkg::in_item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(drsr_pkg::in_item_t)-1:0];
	endfunction

	function automatic drsr_pkg::in_item_t submit_item(input logic u, input logic [15:0] blk,
		input logic [15:0] addr, input logic [7:0] cnt, input logic rd);
		drsr_pkg::in_item_t it;
		it = random_item();
		it.req_type = drsr_pkg::REQ_SUBMIT;
		it.unit = u;
		it.start_block = blk;
		it.buffer_addr = addr;
		it.block_count = cnt;
		it.is_read = rd;
		return it;
	endfunction

	function automatic drsr_pkg::in_item_t event_item(input logic [15:0] status);
		drsr_pkg::in_item_t it;
		it = random_item();
		it.req_type = drsr_pkg::REQ_EVENT;
		it.status_word = status;
		return it;
	endfunction

	function automatic logic [15:0] ok_status();
		return 16'($urandom) & ~drsr_pkg::STATUS_ERR_MASK;
	endfunction

	function automatic logic [15:0] err_status();
		logic [15:0] s;
		s = 16'($urandom);
		s[14:12] = 3'($urandom_range(7, 1));
		return s;
	endfunction

	function automatic logic [15:0] start_in_range();
		if ($urandom_range(19) == 0)
			return 16'(int'(cfg_block_limit) - 1);
		return 16'($urandom_range(int'(cfg_block_limit) - 1, 0));
	endfunction

	// A submit followed by the completions that carry it to its end, with a
	// run of errors on some blocks, sometimes long enough to fail the request.
	task automatic gen_flow(input int cnt);
		int nerr;
		int nblk;
		pending_items.push_back(submit_item(1'($urandom), start_in_range(), 16'($urandom),
			8'(cnt), 1'($urandom)));
		nblk = (cnt == 0) ? 256 : cnt;
		repeat (nblk) begin
			nerr = ($urandom_range(3) == 0) ? $urandom_range(int'(cfg_max_retries) + 1, 1) : 0;
			repeat (nerr) pending_items.push_back(event_item(err_status()));
			pending_items.push_back(event_item(ok_status()));
		end
	endtask

	task automatic gen_phase(input int target);
		int pick;
		int n;
		while (pending_items.size() < target) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				gen_flow(($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(12, 5));
			end else if (pick < 67) begin
				// Runs of 10 to 20 submits back to back, which can fill the queue, then drain it.
				n = $urandom_range(20, 10);
				repeat (n) pending_items.push_back(submit_item(1'($urandom), start_in_range(),
					16'($urandom), 8'd1, 1'($urandom)));
				repeat (n) pending_items.push_back(event_item(ok_status()));
			end else if (pick < 85) begin
				repeat ($urandom_range(3, 1)) pending_items.push_back(random_item());
			end else if (pick < 95) begin
				pending_items.push_back(submit_item(1'($urandom),
					16'($urandom_range(65535, int'(cfg_block_limit))), 16'($urandom),
					8'($urandom), 1'($urandom)));
			end else begin
				pending_items.push_back(event_item(err_status()));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || cmd_valid || expected_rsp.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] val);
		logic [31:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == drsr_pkg::REG_MAX_RETRIES) begin
			cfg_max_retries = val[3:0];
			want = {28'h0, val[3:0]};
		end else begin
			cfg_block_limit = val[12:0];
			want = {19'h0, val[12:0]};
		end
		// Read the register back.
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d readback: expected %h, got %h", $time, idx, want, prdata);
			mismatches++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int retries, input int limit);
		cfg_write(drsr_pkg::REG_MAX_RETRIES, 32'(retries));
		cfg_write(drsr_pkg::REG_BLOCK_LIMIT, 32'(limit));
	endtask

	// Sender.
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_ready) begin
			if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
				cmd_valid <= 1'b1;
				cmd_item <= pending_items.pop_front();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver.
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= steady || $urandom_range(99) >= 14;
	end

	always @(posedge clk) begin
		drsr_pkg::out_item_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_results++;
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected result: outcome %0d unit %0d addr %h cmd %h last %0d",
						$time, rsp_item.outcome, rsp_item.out_unit, rsp_item.out_addr,
						rsp_item.command_word, rsp_item.last);
					mismatches++;
				end else begin
					want = expected_rsp.pop_front();
					case (want.outcome)
						drsr_pkg::OUT_ISSUE: n_issue++;
						drsr_pkg::OUT_DONE_OK: n_done_ok++;
						drsr_pkg::OUT_DONE_ERR: n_done_err++;
						drsr_pkg::OUT_REJ_RANGE: n_rej_range++;
						default: n_rej_full++;
					endcase
					if (rsp_item.outcome !== want.outcome || rsp_item.out_unit !== want.out_unit
						|| rsp_item.out_addr !== want.out_addr
						|| rsp_item.command_word !== want.command_word
						|| rsp_item.last !== want.last) begin
						$display("%0t: expected outcome %0d unit %0d addr %h cmd %h last %0d",
							$time, want.outcome, want.out_unit, want.out_addr,
							want.command_word, want.last);
						$display("%0t:      got outcome %0d unit %0d addr %h cmd %h last %0d",
							$time, rsp_item.outcome, rsp_item.out_unit, rsp_item.out_addr,
							rsp_item.command_word, rsp_item.last);
						mismatches++;
					end
				end
			end
			// The result check comes first so that an item accepted at this edge
			// cannot hide a spurious result.
			if (cmd_valid && cmd_ready) begin
				if (cmd_item.req_type == drsr_pkg::REQ_SUBMIT)
					n_submits++;
				else
					n_events++;
				predict_step(cmd_item);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset settings.
		pending_items.push_back(event_item(16'h0000));
		pending_items.push_back(submit_item(1'b0, 16'd0, 16'h0000, 8'd1, 1'b1));
		pending_items.push_back(submit_item(1'b1, 16'd615, 16'hFFFF, 8'd2, 1'b0));
		pending_items.push_back(submit_item(1'b0, 16'd616, 16'h1234, 8'd3, 1'b1));
		pending_items.push_back(submit_item(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
		pending_items.push_back(event_item(16'h1000));
		pending_items.push_back(event_item(16'h8FFF));
		// One error more than the retry budget fails the second request.
		for (int i = 0; i < 11; i++)
			pending_items.push_back(event_item((16'h1000 << (i % 3)) |
				((i == 10) ? 16'hFFFF : 16'h0)));
		pending_items.push_back(event_item(16'h0FFF));
		pending_items.push_back(event_item(16'hFFFF));
		wait_drained();

		set_config(0, 4096);
		gen_flow(0);
		gen_phase(450);
		wait_drained();

		set_config(15, 1);
		gen_phase(240);
		wait_drained();

		set_config($urandom_range(14, 1), $urandom_range(4096, 1));
		steady = 1'b1;
		gen_phase(240);
		wait_drained();
		steady = 1'b0;

		set_config(15, 4096);
		gen_phase(240);
		wait_drained();

		set_config($urandom_range(15, 0), $urandom_range(4096, 1));
		gen_phase(240);
		wait_drained();

		$display("Sent %0d submits and %0d completion events; checked %0d results.",
			n_submits, n_events, n_results);
		$display("Issued %0d, done ok %0d, done failed %0d, out of range %0d, queue full %0d.",
			n_issue, n_done_ok, n_done_err, n_rej_range, n_rej_full);
		if (mismatches == 0)
			$display("disk_request_sequencer_retry_top verification clean");
		else
			$display("disk_request_sequencer_retry_top verification failed");
		$finish;
	end

endmodule
